### rtl/core/totp_pkg.sv
// TOTP generator package: widths, register indexes, SHA-1 constants.
// No dependencies.
package totp_pkg;
  localparam int unsigned MaxKeyBytes = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CodeW = 30;

  typedef enum logic [CfgIdxW-1:0] {
    RegKey0 = 3'd0, RegKey1 = 3'd1, RegKey2 = 3'd2, RegKey3 = 3'd3,
    RegKeyLen = 3'd4, RegStep = 3'd5, RegDigits = 3'd6, RegNone = 3'd7
  } reg_idx_e;

  localparam logic [159:0] ShaInit =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

  function automatic logic [31:0] rotl1(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

  function automatic logic [29:0] pow10(input logic [3:0] d);
    logic [29:0] r;
    unique case (d)
      4'd1: r = 30'd10;
      4'd2: r = 30'd100;
      4'd3: r = 30'd1000;
      4'd4: r = 30'd10000;
      4'd5: r = 30'd100000;
      4'd6: r = 30'd1000000;
      4'd7: r = 30'd10000000;
      4'd8: r = 30'd100000000;
      default: r = 30'd1000000000;
    endcase
    return r;
  endfunction
endpackage

### rtl/core/totp_hmac_sha1_code_generator.sv
// TOTP top level: register file, 64/32 divider, HMAC sequencer, truncation
// and decimal reduction. Depends on totp_pkg and totp_sha1.
//
// Usage: write key words, key length, time step and digit count on the
// write port (cfg_we_i, cfg_idx_i, cfg_data_i) while idle. Pulse start
// with unix_seconds_i while busy is low; the item is taken at that edge.
// code_valid_o pulses for one cycle with code_value_o when the code is done.
// Steps from the accepting edge to the strobe: restoring division of the
// time by the step, four SHA-1 passes (load the block words, start, the
// compression and a done state; rounds 0..15 read their word directly,
// rounds 16..79 read four schedule words, each read followed by a
// capture), truncation, bit-serial modulo and the output state.
// One item at a time; busy stays high meanwhile, so a new item is taken
// only after the previous one is done.
// Reset sets the configuration registers to their reset values and idles the block.
// The receiver cannot stall: the result is shown for exactly one cycle.
module totp_hmac_sha1_code_generator #(
  parameter int unsigned MAX_KEY_BYTES = totp_pkg::MaxKeyBytes
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [63:0]                    unix_seconds_i,
  output logic                           code_valid_o,
  output logic [totp_pkg::CodeW-1:0]     code_value_o,
  input  logic                           cfg_we_i,
  input  logic [totp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [totp_pkg::CfgDataW-1:0]  cfg_data_i
);
  import totp_pkg::*;

  typedef enum logic [7:0] {
    TIdle = 8'b00000001, TDiv = 8'b00000010, TLoad = 8'b00000100,
    TRun = 8'b00001000, TWait = 8'b00010000, TMod = 8'b00100000,
    TOut = 8'b01000000, TTrunc = 8'b10000000
  } top_state_e;

  logic [63:0] key_q [4];
  logic [5:0]  klen_q;
  logic [31:0] step_q;
  logic [3:0]  digits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      klen_q <= 6'd16;
      step_q <= 32'd30;
      digits_q <= 4'd6;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegKey0: key_q[0] <= cfg_data_i;
        RegKey1: key_q[1] <= cfg_data_i;
        RegKey2: key_q[2] <= cfg_data_i;
        RegKey3: key_q[3] <= cfg_data_i;
        RegKeyLen: klen_q <= cfg_data_i[5:0];
        RegStep: step_q <= cfg_data_i[31:0];
        RegDigits: digits_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  localparam logic [5:0] KMax = 6'(MAX_KEY_BYTES);
  logic [5:0] klen;
  assign klen = (klen_q > KMax) ? KMax : klen_q;

  top_state_e  state_q;
  logic [1:0]  pass_q;
  logic [5:0]  cnt_q;
  logic [63:0] quo_q;
  logic [31:0] rem_q;
  logic [159:0] h_q, dig_q;
  logic [31:0] dt_q;
  logic [29:0] modr_q;
  logic        sha_start, sha_done;
  logic [159:0] sha_h;
  logic [31:0] ld_word;

  // Key word for block word j: bytes 4j..4j+3 masked by length.
  function automatic logic [31:0] key_word32(input logic [3:0] j);
    logic [31:0] w;
    logic [5:0]  b;
    for (int i = 0; i < 4; i++) begin
      b = {1'b0, j[2:0], 2'(i)};
      w[31-8*i -: 8] = (j[3] || b >= klen) ? 8'h00 :
                       key_q[b[4:3]][63-8*b[2:0] -: 8];
    end
    return w;
  endfunction

  always_comb begin
    logic [3:0] j;
    j = cnt_q[3:0];
    unique case (pass_q)
      2'd0: ld_word = key_word32(j) ^ 32'h36363636;
      2'd2: ld_word = key_word32(j) ^ 32'h5C5C5C5C;
      2'd1: begin
        unique case (j)
          4'd0: ld_word = quo_q[63:32];
          4'd1: ld_word = quo_q[31:0];
          4'd2: ld_word = 32'h80000000;
          4'd15: ld_word = 32'd576;
          default: ld_word = 32'd0;
        endcase
      end
      default: begin
        if (j < 4'd5) ld_word = dig_q[159-32*j -: 32];
        else if (j == 4'd5) ld_word = 32'h80000000;
        else if (j == 4'd15) ld_word = 32'd672;
        else ld_word = 32'd0;
      end
    endcase
  end

  assign sha_start = (state_q == TRun);

  totp_sha1 u_sha (
    .clk_i, .rst_ni,
    .load_i(state_q == TLoad),
    .load_addr_i(cnt_q[3:0]),
    .load_data_i(ld_word),
    .start_i(sha_start),
    .h_i(h_q),
    .done_o(sha_done),
    .h_o(sha_h)
  );

  logic [32:0] rem_sh;
  assign rem_sh = {rem_q, quo_q[63]};

  logic [3:0] off;
  logic [7:0] db [4];
  always_comb begin
    off = dig_q[3:0];
    for (int i = 0; i < 4; i++) db[i] = dig_q[159-8*(5'(off)+5'(i)) -: 8];
  end

  logic [3:0]  dg;
  logic [29:0] pm;
  logic [30:0] mr_sh;
  assign dg = (digits_q == 4'd0) ? 4'd1 : (digits_q > 4'd9 ? 4'd9 : digits_q);
  assign pm = pow10(dg);
  assign mr_sh = {modr_q, dt_q[31]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TIdle;
      pass_q <= '0;
      cnt_q <= '0;
    end else begin
      unique case (state_q)
        TIdle: if (start) begin
          state_q <= TDiv; cnt_q <= '0;
        end
        TDiv: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            state_q <= TLoad; cnt_q <= '0; pass_q <= 2'd0;
          end
        end
        TLoad: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd15) state_q <= TRun;
        end
        TRun: state_q <= TWait;
        TWait: if (sha_done) begin
          cnt_q <= '0;
          pass_q <= pass_q + 2'd1;
          state_q <= (pass_q == 2'd3) ? TTrunc : TLoad;
        end
        TTrunc: begin
          state_q <= TMod; cnt_q <= '0;
        end
        TMod: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd31) state_q <= TOut;
        end
        TOut: state_q <= TIdle;
        default: state_q <= TIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      TIdle: begin
        quo_q <= unix_seconds_i;
        rem_q <= '0;
        h_q <= ShaInit;
      end
      TDiv: begin
        if (step_q == 32'd0) begin
          quo_q <= '1;
        end else if (rem_sh >= {1'b0, step_q}) begin
          rem_q <= 32'(rem_sh - {1'b0, step_q});
          quo_q <= {quo_q[62:0], 1'b1};
        end else begin
          rem_q <= rem_sh[31:0];
          quo_q <= {quo_q[62:0], 1'b0};
        end
      end
      TWait: if (sha_done) begin
        h_q <= (pass_q == 2'd1) ? ShaInit : sha_h;
        if (pass_q == 2'd1 || pass_q == 2'd3) dig_q <= sha_h;
      end
      TTrunc: begin
        dt_q <= {1'b0, db[0][6:0], db[1], db[2], db[3]};
        modr_q <= '0;
      end
      TMod: begin
        dt_q <= {dt_q[30:0], 1'b0};
        modr_q <= (mr_sh >= {1'b0, pm}) ? 30'(mr_sh - {1'b0, pm}) : mr_sh[29:0];
      end
      default: ;
    endcase
  end

  assign busy = (state_q != TIdle);
  assign code_valid_o = (state_q == TOut);
  assign code_value_o = modr_q;
endmodule

### rtl/core/totp_sha1.sv
// SHA-1 compression unit, one round at a time; message schedule in a
// 16-word synchronous memory. Depends on totp_pkg.
module totp_sha1 (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  logic [3:0]   load_addr_i,
  input  logic [31:0]  load_data_i,
  input  logic         start_i,
  input  logic [159:0] h_i,
  output logic         done_o,
  output logic [159:0] h_o
);
  import totp_pkg::*;

  typedef enum logic [2:0] {
    SIdle = 3'b001, SRead = 3'b010, SRound = 3'b100
  } sha_state_e;

  logic [31:0] mem_q [16];
  logic [31:0] rd_q;
  logic [3:0]  rd_addr;
  logic [3:0]  wr_addr;
  logic        wr_en;
  logic [31:0] wr_data;
  sha_state_e  state_q, state_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [159:0] hin_q;
  logic [31:0] w_cur, f, k, t;
  logic [31:0] x3_q, x8_q, x14_q;
  logic [1:0]  sub_q, sub_d;
  logic        done_q;

  // Rounds 0..15 read their word directly; later rounds read w[i-3],
  // w[i-8], w[i-14], w[i-16], each read (SRead) followed by a capture (SRound).
  always_comb begin
    unique case (sub_q)
      2'd0: rd_addr = rnd_q[3:0] - 4'd3;
      2'd1: rd_addr = rnd_q[3:0] - 4'd8;
      2'd2: rd_addr = rnd_q[3:0] - 4'd14;
      default: rd_addr = rnd_q[3:0];
    endcase
    if (rnd_q < 7'd16) rd_addr = rnd_q[3:0];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_q <= mem_q[rd_addr];
  end

  assign w_cur = (rnd_q < 7'd16) ? rd_q : rotl1(x3_q ^ x8_q ^ x14_q ^ rd_q);

  always_comb begin
    if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q); k = 32'h5A827999;
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q; k = 32'h6ED9EBA1;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = 32'h8F1BBCDC;
    end else begin
      f = b_q ^ c_q ^ d_q; k = 32'hCA62C1D6;
    end
    t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_cur;
  end

  logic round_go;
  assign round_go = (state_q == SRound) && ((rnd_q < 7'd16) || (sub_q == 2'd3));

  always_comb begin
    wr_en = load_i;
    wr_addr = load_addr_i;
    wr_data = load_data_i;
    if (round_go && rnd_q >= 7'd16) begin
      wr_en = 1'b1;
      wr_addr = rnd_q[3:0];
      wr_data = w_cur;
    end
  end

  always_comb begin
    state_d = state_q;
    rnd_d = rnd_q;
    sub_d = sub_q;
    unique case (state_q)
      SIdle: if (start_i) begin
        state_d = SRead; rnd_d = 7'd0; sub_d = 2'd0;
      end
      SRead: state_d = SRound;
      SRound: begin
        if (round_go) begin
          sub_d = 2'd0;
          rnd_d = rnd_q + 7'd1;
          state_d = (rnd_q == 7'd79) ? SIdle : SRead;
        end else begin
          sub_d = sub_q + 2'd1;
          state_d = SRead;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      rnd_q <= '0;
      sub_q <= '0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rnd_q <= rnd_d;
      sub_q <= sub_d;
      done_q <= round_go && (rnd_q == 7'd79);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && start_i) begin
      hin_q <= h_i;
      {a_q, b_q, c_q, d_q, e_q} <= h_i;
    end else if (state_q == SRound) begin
      unique case (sub_q)
        2'd0: x3_q <= rd_q;
        2'd1: x8_q <= rd_q;
        2'd2: x14_q <= rd_q;
        default: ;
      endcase
      if (round_go) begin
        e_q <= d_q; d_q <= c_q; c_q <= {b_q[1:0], b_q[31:2]};
        b_q <= a_q; a_q <= t;
      end
    end
  end

  assign done_o = done_q;
  assign h_o = {hin_q[159:128] + a_q, hin_q[127:96] + b_q, hin_q[95:64] + c_q,
                hin_q[63:32] + d_q, hin_q[31:0] + e_q};
endmodule
